[rtl/core/nwm_pkg.sv]
// shared types and constants of the noisy-weight matrix-vector block
package nwm_pkg;

  localparam int ADDR_W     = 5;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_CFG_W  = 12;
  localparam int ROW_CFG_W  = 13;
  localparam int GAIN_W     = 16;
  localparam int SEED_W     = 64;
  localparam int ACC_W      = 48;
  localparam int SUM_W      = 32;
  localparam int ROWNUM_W   = 12;
  localparam int NOISE_W    = 16;
  localparam int SNOISE_W   = 17;
  localparam int FRAC_SHIFT = 12;
  localparam int Q16_SHIFT  = 16;
  localparam int XS_SHL_A   = 13;
  localparam int XS_SHR_B   = 7;
  localparam int XS_SHL_C   = 17;
  localparam int NOISE_LSB  = 7;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 12'd512;
  localparam logic [ROW_CFG_W-1:0] ROWS_RESET = 13'd2048;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd19661;
  localparam logic [SEED_W-1:0]    SEED_RESET = 64'd88172645463325252;

  typedef enum logic [1:0] {
    REG_INPUT_LENGTH,
    REG_ROW_COUNT,
    REG_DRIFT_GAIN,
    REG_NOISE_SEED
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOISE,
    S_WMUL,
    S_WSAT,
    S_XMUL,
    S_ACC,
    S_EMIT
  } state_t;

endpackage

[rtl/core/nwm_ram.sv]
// generic single-port ram with registered read
module nwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/noisy_weight_matvec.sv]
// top level of the noisy-weight matrix-vector block
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_ready    | in_op, in_x_value, in_mu_value, in_sigma_value
//  out     | output    | out_valid / out_ready  | out_row_sum, out_row_number, out_last_row
//  cfg     | input     | apb psel/penable/pready| paddr, pwdata, prdata (64-bit registers)
//
// a load item writes the input store in the cycle it is accepted
// a weight item runs its store read, two multiplies, saturation and the accumulate in sequence,
// with an extra multiply step for the noise scale on the first column of a row and an emit
// step on the last column, all sharing one sequencer
// the last column waits in its emit step while the output register is still full
// synchronous active-low reset clears control state; the input store is not cleared
module noisy_weight_matvec #(
  parameter int MAX_INPUT_LENGTH = 2048,
  parameter int MAX_ROWS         = 4096,
  parameter int DATA_WIDTH       = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_op,
  input  logic signed [DATA_WIDTH-1:0]             in_x_value,
  input  logic signed [DATA_WIDTH-1:0]             in_mu_value,
  input  logic signed [DATA_WIDTH-1:0]             in_sigma_value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [nwm_pkg::SUM_W-1:0]         out_row_sum,
  output logic [nwm_pkg::ROWNUM_W-1:0]             out_row_number,
  output logic                                     out_last_row,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [nwm_pkg::ADDR_W-1:0]               paddr,
  input  logic [nwm_pkg::CFG_DATA_W-1:0]           pwdata,
  output logic [nwm_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready
);

  import nwm_pkg::*;

  localparam int IDX_W     = $clog2(MAX_INPUT_LENGTH);
  localparam int LCMP_W    = IDX_W + 1;
  localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCMP_W    = ROW_IDX_W + 1;
  localparam int DW        = DATA_WIDTH;
  localparam int SW_W      = DW + SNOISE_W;
  localparam int PX_W      = 2 * DW;

  // configuration registers
  logic [LEN_CFG_W-1:0] len_cfg_r;
  logic [ROW_CFG_W-1:0] rows_cfg_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [SEED_W-1:0]    seed_r;
  logic                 cfg_wr;
  cfg_reg_t             cfg_sel;

  // sequencer and datapath state
  state_t                      state_r, state_nxt;
  logic [IDX_W-1:0]            load_index_r;
  logic [IDX_W-1:0]            column_index_r;
  logic [ROW_IDX_W-1:0]        row_index_r;
  logic [SEED_W-1:0]           gen_r;
  logic signed [NOISE_W-1:0]   noise_r;
  logic signed [SNOISE_W-1:0]  scaled_noise_r;
  logic signed [DW-1:0]        x_r, mu_r, sigma_r;
  logic signed [SW_W-1:0]      sw_r;
  logic signed [DW-1:0]        w_r;
  logic signed [PX_W-1:0]      px_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic                        out_valid_r;
  logic signed [SUM_W-1:0]     out_sum_r;
  logic [ROWNUM_W-1:0]         out_row_r;
  logic                        out_last_r;

  logic                        accept;
  logic                        emit;
  logic [LCMP_W-1:0]           used_len;
  logic [RCMP_W-1:0]           used_rows;
  logic [IDX_W-1:0]            ld_base;
  logic [LCMP_W-1:0]           ld_inc;
  logic [SEED_W-1:0]           xs1, xs2, xs3;
  logic signed [NOISE_W+SNOISE_W-1:0] sn_prod;
  logic signed [DW+1:0]        wsum;
  logic signed [DW-1:0]        w_sat;
  logic signed [ACC_W-FRAC_SHIFT-1:0] acc_sh;
  logic signed [SUM_W-1:0]     sum_sat;
  logic                        row_end;
  logic                        row_last;
  logic                        ram_en, ram_we;
  logic [IDX_W-1:0]            ram_addr;
  logic [DW-1:0]               ram_rdata;

  // apb: writes in the access phase, reads combinational
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:3]);

  always_comb begin
    case (cfg_sel)
      REG_INPUT_LENGTH: prdata = CFG_DATA_W'(len_cfg_r);
      REG_ROW_COUNT:    prdata = CFG_DATA_W'(rows_cfg_r);
      REG_DRIFT_GAIN:   prdata = CFG_DATA_W'(gain_r);
      REG_NOISE_SEED:   prdata = seed_r;
      default:          prdata = '0;
    endcase
  end

  // lengths in use, clamped to the supported range
  always_comb begin
    if (len_cfg_r == '0) begin
      used_len = LCMP_W'(1);
    end else if (32'(len_cfg_r) > 32'(MAX_INPUT_LENGTH)) begin
      used_len = LCMP_W'(MAX_INPUT_LENGTH);
    end else begin
      used_len = LCMP_W'(len_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      used_rows = RCMP_W'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      used_rows = RCMP_W'(MAX_ROWS);
    end else begin
      used_rows = RCMP_W'(rows_cfg_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // load index restarts if the length shrank under it
  assign ld_base = (LCMP_W'(load_index_r) >= used_len) ? '0 : load_index_r;
  assign ld_inc  = LCMP_W'(ld_base) + LCMP_W'(1);

  // xorshift step
  assign xs1 = gen_r ^ (gen_r << XS_SHL_A);
  assign xs2 = xs1 ^ (xs1 >> XS_SHR_B);
  assign xs3 = xs2 ^ (xs2 << XS_SHL_C);

  // noise scale: signed noise times unsigned gain, floor shift by 16
  assign sn_prod = noise_r * $signed({1'b0, gain_r});

  // weight = mu + floor(sigma * scaled_noise / 2^16), saturated
  assign wsum = $signed({{2{mu_r[DW-1]}}, mu_r})
              + $signed({sw_r[SW_W-1], sw_r[SW_W-1:Q16_SHIFT]});

  always_comb begin
    if ((&wsum[DW+1:DW-1]) || !(|wsum[DW+1:DW-1])) begin
      w_sat = wsum[DW-1:0];
    end else if (wsum[DW+1]) begin
      w_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // row sum: floor by 2^12 and saturate to 32 bits
  assign acc_sh = acc_r[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if ((&acc_sh[ACC_W-FRAC_SHIFT-1:SUM_W-1]) || !(|acc_sh[ACC_W-FRAC_SHIFT-1:SUM_W-1])) begin
      sum_sat = acc_sh[SUM_W-1:0];
    end else if (acc_sh[ACC_W-FRAC_SHIFT-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  assign row_end  = (LCMP_W'(column_index_r) + LCMP_W'(1)) >= used_len;
  assign row_last = (RCMP_W'(row_index_r) + RCMP_W'(1)) >= used_rows;
  assign emit     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // store: load items write, weight items read the current column
  assign ram_en   = accept;
  assign ram_we   = accept && !in_op;
  assign ram_addr = in_op ? column_index_r : ld_base;

  nwm_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_INPUT_LENGTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_x_value),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op) begin
          state_nxt = (column_index_r == '0) ? S_NOISE : S_WMUL;
        end
      end
      S_NOISE: state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_WSAT;
      S_WSAT:  state_nxt = S_XMUL;
      S_XMUL:  state_nxt = S_ACC;
      S_ACC:   state_nxt = row_end ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r      <= LEN_RESET;
      rows_cfg_r     <= ROWS_RESET;
      gain_r         <= GAIN_RESET;
      seed_r         <= SEED_RESET;
      gen_r          <= SEED_RESET;
      scaled_noise_r <= '0;
      acc_r          <= '0;
      load_index_r   <= '0;
      column_index_r <= '0;
      row_index_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_sel)
          REG_INPUT_LENGTH: len_cfg_r  <= pwdata[LEN_CFG_W-1:0];
          REG_ROW_COUNT:    rows_cfg_r <= pwdata[ROW_CFG_W-1:0];
          REG_DRIFT_GAIN:   gain_r     <= pwdata[GAIN_W-1:0];
          REG_NOISE_SEED: begin
            seed_r <= pwdata;
            gen_r  <= pwdata;
          end
          default: ;
        endcase
      end
      // load item: write then advance, wrapping at the length
      if (accept && !in_op) begin
        load_index_r <= (ld_inc >= used_len) ? '0 : ld_inc[IDX_W-1:0];
      end
      // first column of a row steps the generator
      if (accept && in_op && (column_index_r == '0)) begin
        gen_r <= xs3;
      end
      if (state_r == S_NOISE) begin
        scaled_noise_r <= sn_prod[NOISE_W+SNOISE_W-1:Q16_SHIFT];
      end
      if (state_r == S_ACC) begin
        acc_r <= ((column_index_r == '0) ? '0 : acc_r) + ACC_W'(px_r);
        if (!row_end) begin
          column_index_r <= column_index_r + IDX_W'(1);
        end
      end
      if (emit) begin
        column_index_r <= '0;
        row_index_r    <= row_last ? '0 : row_index_r + ROW_IDX_W'(1);
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && in_op) begin
      mu_r    <= in_mu_value;
      sigma_r <= in_sigma_value;
      noise_r <= $signed({~xs3[NOISE_LSB+NOISE_W-1], xs3[NOISE_LSB+NOISE_W-2:NOISE_LSB]});
    end
    if (state_r == S_WMUL) begin
      sw_r <= sigma_r * scaled_noise_r;
      x_r  <= ram_rdata;
    end
    if (state_r == S_WSAT) begin
      w_r <= w_sat;
    end
    if (state_r == S_XMUL) begin
      px_r <= x_r * w_r;
    end
    if (emit) begin
      out_sum_r  <= sum_sat;
      out_row_r  <= ROWNUM_W'(row_index_r);
      out_last_r <= row_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_sum    = out_sum_r;
  assign out_row_number = out_row_r;
  assign out_last_row   = out_last_r;

endmodule
